@@ sv/tsb_pkg.sv @@
// Shared types, constants and the build-time thermistor conversion function
// for the thermostat block. No dependencies.
package tsb_pkg;

    localparam int ADC_W   = 10;
    localparam int TEMP_W  = 10;
    localparam int TGT_W   = 7;

    localparam logic [TGT_W-1:0] EDIT_MIN     = 7'd10;
    localparam logic [TGT_W-1:0] EDIT_MAX     = 7'd99;
    localparam logic [TGT_W-1:0] TARGET_RESET = 7'd70;
    localparam logic [15:0]      ELAPSED_MAX  = 16'hFFFF;

    // Steinhart-Hart terms, fixed point (see tsb_convert)
    localparam logic [63:0] COEF_A    = 64'd10092495220000;
    localparam logic [63:0] COEF_B    = 64'd2378405444000;
    localparam logic [63:0] COEF_C    = 64'd2019202697;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [63:0] HEAT_NUM  = 64'd1800000000000000000;
    localparam logic signed [63:0] ZERO_F_HUNDREDTHS = 64'sd45967;
    localparam logic signed [63:0] COLD_LIMIT = -64'sd459;
    localparam logic signed [63:0] HOT_LIMIT  = 64'sd511;
    localparam logic signed [63:0] SAT_LOW    = -64'sd512;

    typedef logic signed [TEMP_W-1:0] t_temp;

    typedef enum logic [1:0] {
        OP_SAMPLE    = 2'd0,
        OP_TICK_IDLE = 2'd1,
        OP_TICK_UP   = 2'd2,
        OP_TICK_DOWN = 2'd3
    } t_op_kind;

    typedef enum logic [1:0] {
        KIND_TEMP = 2'd0,
        KIND_EDIT = 2'd1,
        KIND_SAVE = 2'd2
    } t_kind;

    typedef struct packed {
        t_op_kind           kind;
        logic [ADC_W-1:0]   adc;
    } t_op;

    typedef struct packed {
        t_kind              kind;
        t_temp              temp;
        logic               pump;
        logic [TGT_W-1:0]   target;
        logic [TGT_W-1:0]   edit;
    } t_result;

    typedef struct packed {
        logic [3:0]  band;
        logic [9:0]  debounce;
        logic [15:0] timeout;
    } t_cfg;

    // Elaboration-time helpers only; never used on signals.
    function automatic logic [63:0] tsb_udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], n[i]};
            if (rem >= {1'b0, d}) begin
                rem    = rem - {1'b0, d};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // log2 in Q28 by repeated squaring of the normalised mantissa
    function automatic logic [63:0] tsb_log2_q28(input logic [31:0] x);
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] e;
        e    = '0;
        frac = '0;
        if (x == 32'd0) begin
            return 64'd0;
        end
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                e = 64'(i);
            end
        end
        if (e <= 64'd30) begin
            m = 64'(x) << (64'd30 - e);
        end else begin
            m = 64'(x) >> (e - 64'd30);
        end
        for (int i = 0; i < 28; i++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (e << 28) | frac;
    endfunction

    function automatic t_temp tsb_convert(input logic [31:0] a, input logic [31:0] fs);
        logic [31:0]        r;
        logic [63:0]        lr;
        logic [63:0]        la;
        logic [63:0]        lg;
        logic [63:0]        ln;
        logic [63:0]        l3;
        logic [63:0]        d;
        logic [63:0]        q;
        logic [63:0]        mag;
        logic signed [63:0] h;
        logic signed [63:0] f;
        if (a == 32'd0) begin
            f = COLD_LIMIT;
        end else if (a >= fs) begin
            f = HOT_LIMIT;
        end else begin
            r  = 32'd10000 * (fs - a);
            lr = tsb_log2_q28(r);
            la = tsb_log2_q28(a);
            lg = (lr > la) ? (lr - la) : 64'd0;
            ln = (lg * LN2_Q30) >> 42;
            l3 = (((ln * ln) >> 16) * ln) >> 16;
            d  = COEF_A + ((COEF_B * ln) >> 16) + ((COEF_C * l3) >> 16);
            q  = tsb_udiv64(HEAT_NUM, d);
            h  = $signed(q) - ZERO_F_HUNDREDTHS;
            if (h < 0) begin
                mag = tsb_udiv64(64'(-h), 64'd100);
                f   = -$signed(mag);
            end else begin
                mag = tsb_udiv64(64'(h), 64'd100);
                f   = $signed(mag);
            end
            if (f > HOT_LIMIT) begin
                f = HOT_LIMIT;
            end
            if (f < SAT_LOW) begin
                f = SAT_LOW;
            end
        end
        return t_temp'(f[TEMP_W-1:0]);
    endfunction

endpackage

@@ sv/thermostat_with_setpoint_buttons.sv @@
// Top level of the thermostat: config registers, input stage, op queue,
// executor and result queue. Depends on tsb_pkg, tsb_queue, tsb_front, tsb_back.
//
//  channel | side | handshake                     | payload
//  --------+------+-------------------------------+-----------------------------------------
//  input   | in   | push, full                    | i_action i_adc_value i_button_up/_down
//  result  | out  | empty, pop                    | o_report_kind o_temperature_f o_pump_on
//          |      |                               | o_target_f o_edit_value
//  config  | in   | psel, penable, pwrite, pready | paddr pwdata prdata
//
// Items are taken one per clock while the queues have room. Each completed
// reading occupies the executor through reciprocal multiply, ROM read port and
// pump compare; the four-entry op queue soaks that up, so input stalls only
// when it fills. A tick result passes the front register, op queue and result
// queue; a reading's result passes those steps as well. Reset is synchronous,
// active low, and returns the state registers and queue pointers to their reset
// values; the ROM is constant, so there is no fill pass. A full result queue
// stalls the executor, which in turn backs up the op queue and finally raises full.
module thermostat_with_setpoint_buttons
    import tsb_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 20,
    parameter int ADC_BITS            = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input items
    input  logic              push,
    output logic              full,
    input  logic              i_action,
    input  logic [ADC_W-1:0]  i_adc_value,
    input  logic              i_button_up,
    input  logic              i_button_down,
    // results
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        o_report_kind,
    output logic signed [TEMP_W-1:0] o_temperature_f,
    output logic              o_pump_on,
    output logic [TGT_W-1:0]  o_target_f,
    output logic [TGT_W-1:0]  o_edit_value,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int OP_QUEUE_DEPTH  = 4;
    localparam int RES_QUEUE_DEPTH = 2;

    // register map, byte address = 4 * index
    localparam logic [1:0] REG_BAND     = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    localparam logic [3:0]  BAND_RESET     = 4'd2;
    localparam logic [9:0]  DEBOUNCE_RESET = 10'd250;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd5000;

    t_cfg    r_cfg;
    logic    w_cfg_wr;
    logic    w_op_wr;
    t_op     w_op;
    logic    w_op_full;
    logic    w_op_empty;
    logic [$bits(t_op)-1:0]     w_op_rdata;
    logic    w_op_take;
    logic    w_res_wr;
    t_result w_res;
    logic    w_res_full;
    logic [$bits(t_result)-1:0] w_res_rdata;
    t_result w_head;

    // ---------------------------------------------------------------------
    // Register port: zero wait states, write lands in the access phase.
    // Writes to the unused slot are dropped.
    // ---------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band     <= BAND_RESET;
            r_cfg.debounce <= DEBOUNCE_RESET;
            r_cfg.timeout  <= TIMEOUT_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_BAND:     r_cfg.band     <= pwdata[3:0];
                REG_DEBOUNCE: r_cfg.debounce <= pwdata[9:0];
                REG_TIMEOUT:  r_cfg.timeout  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BAND:     prdata = {28'b0, r_cfg.band};
            REG_DEBOUNCE: prdata = {22'b0, r_cfg.debounce};
            REG_TIMEOUT:  prdata = {16'b0, r_cfg.timeout};
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Front: one register stage that tags each item as a sample or a tick
    // with its button action.
    // ---------------------------------------------------------------------
    tsb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_action      (i_action),
        .i_adc_value   (i_adc_value),
        .i_button_up   (i_button_up),
        .i_button_down (i_button_down),
        .o_op_wr       (w_op_wr),
        .o_op          (w_op),
        .i_op_full     (w_op_full)
    );

    // decouples the front from the executor's reading bubbles
    tsb_queue #(
        .WIDTH ($bits(t_op)),
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_op_wr),
        .i_wdata (w_op),
        .o_full  (w_op_full),
        .i_rd    (w_op_take),
        .o_rdata (w_op_rdata),
        .o_empty (w_op_empty)
    );

    // ---------------------------------------------------------------------
    // Back: all model state lives here. Ops are taken in order, one per clock,
    // except while a reading works through divide, ROM and compare or the result queue is full.
    // ---------------------------------------------------------------------
    tsb_back #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING),
        .ADC_BITS            (ADC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_op_valid (!w_op_empty),
        .i_op       (t_op'(w_op_rdata)),
        .o_op_take  (w_op_take),
        .i_res_full (w_res_full),
        .o_res_wr   (w_res_wr),
        .o_res      (w_res)
    );

    // result queue: the executor keeps going while a report waits for pop
    tsb_queue #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_res_wr),
        .i_wdata (w_res),
        .o_full  (w_res_full),
        .i_rd    (pop),
        .o_rdata (w_res_rdata),
        .o_empty (empty)
    );

    assign w_head          = t_result'(w_res_rdata);
    assign o_report_kind   = w_head.kind;
    assign o_temperature_f = w_head.temp;
    assign o_pump_on       = w_head.pump;
    assign o_target_f      = w_head.target;
    assign o_edit_value    = w_head.edit;

endmodule

@@ sv/tsb_queue.sv @@
// Small first-in first-out register queue, used for the op queue and the
// result queue. No package dependency.
module tsb_queue #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_wr;
    logic             w_do_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign w_do_wr = i_wr && !o_full;
    assign w_do_rd = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_do_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_do_wr && !w_do_rd) begin
            n_count = r_count + CW'(1);
        end else if (!w_do_wr && w_do_rd) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

@@ sv/tsb_front.sv @@
// Input stage: takes items, sorts them into sample / tick ops and hands
// them to the op queue. Depends on tsb_pkg.
module tsb_front
    import tsb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic             i_action,
    input  logic [ADC_W-1:0] i_adc_value,
    input  logic             i_button_up,
    input  logic             i_button_down,
    output logic             o_op_wr,
    output t_op              o_op,
    input  logic             i_op_full
);

    logic r_valid;
    t_op  r_op;
    t_op  w_op;
    logic w_accept;

    // up wins when both buttons are held
    always_comb begin
        w_op.adc = i_adc_value;
        if (!i_action) begin
            w_op.kind = OP_SAMPLE;
        end else if (i_button_up) begin
            w_op.kind = OP_TICK_UP;
        end else if (i_button_down) begin
            w_op.kind = OP_TICK_DOWN;
        end else begin
            w_op.kind = OP_TICK_IDLE;
        end
    end

    assign o_full   = r_valid && i_op_full;
    assign w_accept = i_push && !o_full;
    assign o_op_wr  = r_valid && !i_op_full;
    assign o_op     = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_op_wr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= w_op;
        end
    end

endmodule

@@ sv/tsb_back.sv @@
// Executor: sample averaging, conversion ROM, pump hysteresis and the
// setpoint edit logic. Depends on tsb_pkg.
module tsb_back
    import tsb_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 20,
    parameter int ADC_BITS            = 10
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_op_valid,
    input  t_op     i_op,
    output logic    o_op_take,
    input  logic    i_res_full,
    output logic    o_res_wr,
    output t_result o_res
);

    localparam int          DEPTH = 2 ** ADC_BITS;
    localparam logic [31:0] FS    = 32'(DEPTH - 1);
    localparam int          SW    = ADC_W + $clog2(SAMPLES_PER_READING);
    localparam int          CW    = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam int          SH    = SW + $clog2(SAMPLES_PER_READING);
    // ceil(2^SH / N): exact quotient for every sum below 2^SW
    localparam logic [SH:0] RECIP =
        (SH + 1)'(((64'd1 << SH) + 64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING));

    // conversion ROM, built at elaboration
    t_temp w_rom [DEPTH];
    for (genvar g = 0; g < DEPTH; g++) begin : g_rom
        localparam t_temp ENTRY = tsb_convert(32'(g), FS);
        assign w_rom[g] = ENTRY;
    end

    logic [SW-1:0]       r_sum, n_sum;
    logic [CW-1:0]       r_count, n_count;
    t_temp               r_last_temp, n_last_temp;
    logic                r_pump, n_pump;
    logic [TGT_W-1:0]    r_target, n_target;
    logic                r_editing, n_editing;
    logic [TGT_W-1:0]    r_edit, n_edit;
    logic [15:0]         r_elapsed, n_elapsed;
    logic                r_v1, n_v1;
    logic                r_v2;
    logic                r_v3;
    logic [SW-1:0]       r_total;
    logic [ADC_BITS-1:0] r_avg, n_avg;
    t_temp               r_rom_q;

    logic                w_busy;
    logic [SW-1:0]       w_total;
    logic                w_pressed;
    logic [15:0]         w_el_inc;
    logic                w_step;
    logic [SW+SH:0]      w_prod;
    logic [SW-1:0]       w_avg_full;
    logic signed [11:0]  w_t_ext;
    logic signed [11:0]  w_hi;
    logic signed [11:0]  w_lo;

    // one reading in flight at a time keeps reports and target updates in order
    assign w_busy    = r_v1 || r_v2 || r_v3;
    assign o_op_take = i_op_valid && !w_busy && !i_res_full;
    assign w_total   = r_sum + SW'(i_op.adc);
    assign w_pressed = (i_op.kind == OP_TICK_UP) || (i_op.kind == OP_TICK_DOWN);
    assign w_el_inc  = (r_elapsed != ELAPSED_MAX) ? r_elapsed + 16'd1 : r_elapsed;
    assign w_step    = w_pressed && (w_el_inc > {6'b0, i_cfg.debounce});

    // divide by the group size through the reciprocal
    assign w_prod     = r_total * RECIP;
    assign w_avg_full = w_prod[SH +: SW];
    always_comb begin
        if (32'(w_avg_full) > FS) begin
            n_avg = ADC_BITS'(FS);
        end else begin
            n_avg = ADC_BITS'(w_avg_full);
        end
    end

    assign w_t_ext = {{2{r_rom_q[TEMP_W-1]}}, r_rom_q};
    assign w_hi    = $signed({5'b0, r_target}) + $signed({8'b0, i_cfg.band});
    assign w_lo    = $signed({5'b0, r_target}) - $signed({8'b0, i_cfg.band});

    always_comb begin
        n_sum       = r_sum;
        n_count     = r_count;
        n_last_temp = r_last_temp;
        n_pump      = r_pump;
        n_target    = r_target;
        n_editing   = r_editing;
        n_edit      = r_edit;
        n_elapsed   = r_elapsed;
        n_v1        = 1'b0;
        o_res_wr    = 1'b0;
        o_res       = '{kind: KIND_TEMP, temp: r_last_temp, pump: r_pump,
                        target: r_target, edit: r_edit};

        if (o_op_take) begin
            unique case (i_op.kind) inside
                OP_SAMPLE: begin
                    if (!r_editing) begin
                        if (r_count == CW'(SAMPLES_PER_READING - 1)) begin
                            n_sum   = '0;
                            n_count = '0;
                            n_v1    = 1'b1;
                        end else begin
                            n_sum   = w_total;
                            n_count = r_count + CW'(1);
                        end
                    end
                end
                OP_TICK_IDLE, OP_TICK_UP, OP_TICK_DOWN: begin
                    if (!r_editing) begin
                        if (w_pressed) begin
                            n_editing = 1'b1;
                            n_edit    = r_target;
                            n_elapsed = '0;
                        end
                    end else if (w_step) begin
                        if (i_op.kind == OP_TICK_UP) begin
                            n_edit = (r_edit >= EDIT_MAX) ? EDIT_MIN : r_edit + TGT_W'(1);
                        end else begin
                            n_edit = (r_edit <= EDIT_MIN) ? EDIT_MAX : r_edit - TGT_W'(1);
                        end
                        n_elapsed  = '0;
                        o_res_wr   = 1'b1;
                        o_res.kind = KIND_EDIT;
                        o_res.edit = n_edit;
                    end else if (w_el_inc >= i_cfg.timeout) begin
                        n_elapsed    = w_el_inc;
                        n_target     = r_edit;
                        n_editing    = 1'b0;
                        o_res_wr     = 1'b1;
                        o_res.kind   = KIND_SAVE;
                        o_res.target = r_edit;
                    end else begin
                        n_elapsed = w_el_inc;
                    end
                end
                default: begin
                end
            endcase
        end

        // last step of a reading: pump decision and temperature report
        if (r_v3) begin
            n_last_temp = r_rom_q;
            if (w_t_ext > w_hi) begin
                n_pump = 1'b1;
            end else if (w_t_ext <= w_lo) begin
                n_pump = 1'b0;
            end
            o_res_wr    = 1'b1;
            o_res.kind  = KIND_TEMP;
            o_res.temp  = r_rom_q;
            o_res.pump  = n_pump;
            o_res.edit  = r_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            r_last_temp <= '0;
            r_pump      <= 1'b0;
            r_target    <= TARGET_RESET;
            r_editing   <= 1'b0;
            r_edit      <= TARGET_RESET;
            r_elapsed   <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_last_temp <= n_last_temp;
            r_pump      <= n_pump;
            r_target    <= n_target;
            r_editing   <= n_editing;
            r_edit      <= n_edit;
            r_elapsed   <= n_elapsed;
            r_v1        <= n_v1;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_v1) begin
            r_total <= w_total;
        end
        if (r_v1) begin
            r_avg <= n_avg;
        end
        if (r_v2) begin
            r_rom_q <= w_rom[r_avg];
        end
    end

    a_stage_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_v1, r_v2, r_v3}))
        else $error("more than one reading in flight");

    a_reading_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> ##2 (o_res_wr && o_res.kind == KIND_TEMP))
        else $error("reading did not produce a temperature report");

    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_wr |-> !i_res_full)
        else $error("result written into a full queue");

    a_no_read_in_edit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op_take && r_editing) |=> !r_v1)
        else $error("reading started while editing");

    a_edit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_edit >= EDIT_MIN) && (r_edit <= EDIT_MAX)
        && (r_target >= EDIT_MIN) && (r_target <= EDIT_MAX))
        else $error("setpoint out of range");

endmodule
